[design/ftr_pkg.sv]
// Package for the fan tachometer speed block.
// Holds widths, constants and the command and status types shared by the
// controller, the datapath and the top level. Depends on nothing.
`timescale 1ns / 1ps

package ftr_pkg;

  localparam int SPEED_W    = 25;
  localparam int STALL_W    = 8;
  localparam int QCNT_W     = $clog2(SPEED_W);
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // 60,000,000 / (2 * elapsed) equals 30,000,000 / elapsed exactly.
  localparam logic [SPEED_W-1:0] SPEED_DIVIDEND = SPEED_W'(30000000);
  localparam logic [STALL_W-1:0] TIMEOUT_RST    = STALL_W'(10);

  localparam logic ACT_EDGE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  localparam logic REG_TIMEOUT = 1'b0;

  typedef struct packed {
    logic accept_edge;
    logic accept_tick;
    logic div_step;
    logic load_out;
  } ftr_cmd_t;

  typedef struct packed {
    logic elapsed_zero;
    logic div_last;
  } ftr_sts_t;

endpackage

[design/ftr_ctrl.sv]
// Controller for the fan tachometer speed block.
// Sequences item acceptance, the divider steps and the output register.
// Depends on ftr_pkg.
`timescale 1ns / 1ps

module ftr_ctrl
  import ftr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_action,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  ftr_sts_t sts,
  output ftr_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;
  logic       accept;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    cmd             = '0;
    state_nxt       = state_r;
    cmd.accept_edge = accept && (in_action == ACT_EDGE);
    cmd.accept_tick = accept && (in_action == ACT_TICK);
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if ((in_action == ACT_EDGE) && !sts.elapsed_zero) begin
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[design/ftr_dp.sv]
// Datapath for the fan tachometer speed block.
// Holds the edge, stall and speed state, a one-bit-per-cycle restoring
// divider and the output register. Depends on ftr_pkg.
`timescale 1ns / 1ps

module ftr_dp
  import ftr_pkg::*;
#(
  parameter int COUNTER_BITS = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [COUNTER_BITS-1:0] in_timer_count,
  input  logic [STALL_W-1:0]      timeout,
  input  ftr_cmd_t                cmd,
  output ftr_sts_t                sts,
  output logic [SPEED_W-1:0]      out_speed_rpm
);

  logic [COUNTER_BITS-1:0] last_r;
  logic [STALL_W-1:0]      stall_r;
  logic [SPEED_W-1:0]      speed_r;
  logic [COUNTER_BITS-1:0] div_r;
  logic [COUNTER_BITS-1:0] rem_r;
  logic [COUNTER_BITS-1:0] rem_nxt;
  logic [SPEED_W-1:0]      quo_r;
  logic [SPEED_W-1:0]      quo_nxt;
  logic [QCNT_W-1:0]       cnt_r;
  logic [SPEED_W-1:0]      out_r;
  logic [COUNTER_BITS-1:0] elapsed;
  logic [COUNTER_BITS:0]   rem_shift;
  logic [COUNTER_BITS:0]   rem_diff;
  logic                    q_bit;

  assign elapsed          = in_timer_count - last_r;
  assign sts.elapsed_zero = (elapsed == '0);
  assign sts.div_last     = (cnt_r == QCNT_W'(SPEED_W - 1));
  assign out_speed_rpm    = out_r;

  assign rem_shift = {rem_r, quo_r[SPEED_W-1]};
  assign rem_diff  = rem_shift - {1'b0, div_r};
  assign q_bit     = !rem_diff[COUNTER_BITS];
  assign rem_nxt   = q_bit ? rem_diff[COUNTER_BITS-1:0] : rem_shift[COUNTER_BITS-1:0];
  assign quo_nxt   = {quo_r[SPEED_W-2:0], q_bit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= '0;
      stall_r <= '0;
      speed_r <= '0;
    end else begin
      if (cmd.accept_edge) begin
        last_r  <= in_timer_count;
        stall_r <= '0;
      end else if (cmd.accept_tick) begin
        if (stall_r >= timeout) begin
          speed_r <= '0;
          stall_r <= timeout;
        end else begin
          stall_r <= stall_r + STALL_W'(1);
        end
      end
      if (cmd.div_step && sts.div_last) begin
        speed_r <= quo_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_edge) begin
      div_r <= elapsed;
      rem_r <= '0;
      quo_r <= SPEED_DIVIDEND;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r + QCNT_W'(1);
    end
    if (cmd.load_out) begin
      out_r <= speed_r;
    end
  end

endmodule

[design/fan_tach_rpm_with_stall_timeout_top.sv]
// Top level of the fan tachometer speed block with stall timeout.
// Holds the configuration register and joins ftr_ctrl and ftr_dp.
// Depends on ftr_pkg, ftr_ctrl and ftr_dp.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_stall  in_action, in_timer_count
//   out_     output     out_valid/out_stall out_speed_rpm
//   cfg      input      psel/penable/...   stall_timeout_ticks at byte address 0
//
// A tick item, or an edge item with a zero interval, goes from idle straight to
// the response state. An edge item with a non-zero interval first passes through
// the restoring divider, which produces one quotient bit per cycle over 25 bits.
// Reset is synchronous, active low, and clears state, speed and the timeout to 10.
// A new item is taken while a finished result still waits in the output register.
`timescale 1ns / 1ps

module fan_tach_rpm_with_stall_timeout_top
  import ftr_pkg::*;
#(
  parameter int COUNTER_BITS = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_action,
  input  logic [COUNTER_BITS-1:0] in_timer_count,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [SPEED_W-1:0]      out_speed_rpm,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CFG_ADDR_W-1:0]   paddr,
  input  logic [CFG_DATA_W-1:0]   pwdata,
  output logic [CFG_DATA_W-1:0]   prdata,
  output logic                    pready
);

  logic [STALL_W-1:0] timeout_r;
  logic               reg_sel;
  ftr_cmd_t           cmd;
  ftr_sts_t           sts;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_TIMEOUT);
  assign prdata  = reg_sel ? CFG_DATA_W'(timeout_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      timeout_r <= pwdata[STALL_W-1:0];
    end
  end

  ftr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ftr_dp #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_timer_count (in_timer_count),
    .timeout        (timeout_r),
    .cmd            (cmd),
    .sts            (sts),
    .out_speed_rpm  (out_speed_rpm)
  );

endmodule

[bench/ftr_checker.sv]
// Checker for the fan tachometer speed block: watches the item, result and register ports.
// It predicts each speed reading and compares it with the block's output.
// Depends on ftr_pkg.
`timescale 1ns / 1ps

module ftr_checker
  import ftr_pkg::*;
#(
  parameter int COUNTER_BITS = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic                    in_action,
  input  logic [COUNTER_BITS-1:0] in_timer_count,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [SPEED_W-1:0]      out_speed_rpm,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic                    pready,
  input  logic [CFG_ADDR_W-1:0]   paddr,
  input  logic [CFG_DATA_W-1:0]   pwdata,
  output int                      bad_results,
  output int                      speeds_owed
);

  logic [COUNTER_BITS-1:0] prev_edge_count;
  logic [COUNTER_BITS-1:0] elapsed;
  logic [STALL_W-1:0]      ticks_since_edge;
  logic [STALL_W-1:0]      timeout_ticks;
  logic [SPEED_W-1:0]      speed_now;
  logic [SPEED_W-1:0]      owed_speed;
  logic [SPEED_W-1:0]      speed_q[$];

  function automatic logic [SPEED_W-1:0] rpm_from_period(input logic [COUNTER_BITS-1:0] period);
    longint unsigned half_turns;
    half_turns = 2 * longint'(period);
    return SPEED_W'(64'd60000000 / half_turns);
  endfunction

  task automatic flag_mismatch(input string what);
    $display("ftr_checker: %0t ns: %s", $time, what);
    bad_results++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      prev_edge_count = '0;
      ticks_since_edge = '0;
      timeout_ticks = TIMEOUT_RST;
      speed_now = '0;
      speed_q.delete();
      speeds_owed = 0;
    end else begin
      if (psel && penable && pwrite && pready && (paddr >> 2) == CFG_ADDR_W'(REG_TIMEOUT)) begin
        timeout_ticks = pwdata[STALL_W-1:0];
      end
      if (in_valid && !in_stall) begin
        if (in_action == ACT_EDGE) begin
          elapsed = in_timer_count - prev_edge_count;
          prev_edge_count = in_timer_count;
          ticks_since_edge = '0;
          if (elapsed != '0) speed_now = rpm_from_period(elapsed);
        end else if (ticks_since_edge >= timeout_ticks) begin
          speed_now = '0;
          ticks_since_edge = timeout_ticks;
        end else begin
          ticks_since_edge = ticks_since_edge + 1'b1;
        end
        speed_q.push_back(speed_now);
      end
      if (out_valid && !out_stall) begin
        if (speed_q.size() == 0) begin
          flag_mismatch($sformatf("speed %0d rpm arrived with no item pending", out_speed_rpm));
        end else begin
          owed_speed = speed_q.pop_front();
          if (out_speed_rpm !== owed_speed) begin
            flag_mismatch($sformatf("speed_rpm is %0d, expected %0d", out_speed_rpm, owed_speed));
          end
        end
      end
      speeds_owed = speed_q.size();
    end
  end

endmodule

[bench/tb_fan_tach_rpm_with_stall_timeout_top.sv]
// Testbench top for the fan tachometer speed block: clock, reset, items, register writes.
// Directed cases come first, then random phases with varied timeouts, input idling and output stalls.
// Depends on ftr_pkg, ftr_checker and fan_tach_rpm_with_stall_timeout_top.
`timescale 1ns / 1ps

module tb_fan_tach_rpm_with_stall_timeout_top;
  import ftr_pkg::*;

  localparam int CNT_W       = 24;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 250;
  localparam logic [CFG_ADDR_W-1:0] ADDR_TIMEOUT = CFG_ADDR_W'(4 * REG_TIMEOUT);
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNUSED  = CFG_ADDR_W'(4);

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_action = ACT_EDGE;
  logic [CNT_W-1:0]      in_timer_count = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [SPEED_W-1:0]    out_speed_rpm;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int               bad_results;
  int               speeds_owed;
  int               cycles = 0;
  int               send_idle_pct = 0;
  int               stall_pct = 0;
  logic [CNT_W-1:0] last_edge_sent = '0;
  logic [STALL_W-1:0] timeout_now;

  fan_tach_rpm_with_stall_timeout_top #(
    .COUNTER_BITS(CNT_W)
  ) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_action(in_action), .in_timer_count(in_timer_count),
    .out_valid(out_valid), .out_stall(out_stall), .out_speed_rpm(out_speed_rpm),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ftr_checker #(
    .COUNTER_BITS(CNT_W)
  ) i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_action(in_action), .in_timer_count(in_timer_count),
    .out_valid(out_valid), .out_stall(out_stall), .out_speed_rpm(out_speed_rpm),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .bad_results(bad_results), .speeds_owed(speeds_owed)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_fan_tach_rpm_with_stall_timeout_top: done, errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic send_item(input logic act, input logic [CNT_W-1:0] count);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_action <= 1'($urandom);
      in_timer_count <= CNT_W'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_timer_count <= count;
    do @(posedge clk); while (in_stall);
    if (act == ACT_EDGE) last_edge_sent = count;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (speeds_owed != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_timeout(input logic [STALL_W-1:0] ticks);
    timeout_now = ticks;
    write_register(ADDR_TIMEOUT, {(CFG_DATA_W - STALL_W)'($urandom), ticks});
  endtask

  function automatic logic [CNT_W-1:0] next_edge_count(input logic [CNT_W-1:0] prev);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return prev;
    if (pick < 20) return prev + CNT_W'($urandom_range(1, 64));
    if (pick < 70) return prev + CNT_W'($urandom_range(500, 200000));
    if (pick < 90) return prev + CNT_W'($urandom);
    return CNT_W'($urandom);
  endfunction

  task automatic random_items(input int count);
    int sent;
    int run;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 55) begin
        send_item(ACT_EDGE, next_edge_count(last_edge_sent));
        sent++;
      end else begin
        run = $urandom_range(1, int'(timeout_now) + 3);
        if (run > count - sent) run = count - sent;
        repeat (run) begin
          send_item(ACT_TICK, CNT_W'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_timeout(STALL_W'(10));
    send_item(ACT_EDGE, CNT_W'(1));
    send_item(ACT_EDGE, CNT_W'(1));
    send_item(ACT_EDGE, CNT_W'(0));
    send_item(ACT_EDGE, 24'hFFFFFF);
    send_item(ACT_EDGE, 24'h00752F);
    repeat (11) send_item(ACT_TICK, 24'hFFFFFF);
    send_item(ACT_EDGE, 24'h00752F);
    drain_results();

    write_register(ADDR_UNUSED, '0);
    set_timeout(STALL_W'(0));
    send_item(ACT_EDGE, 24'h007531);
    send_item(ACT_TICK, 24'h000000);
    send_item(ACT_EDGE, 24'h800000);
    drain_results();

    set_timeout(STALL_W'(255));
    send_item(ACT_EDGE, 24'h801000);
    repeat (4) send_item(ACT_TICK, 24'h5A5A5A);
    drain_results();
    set_timeout(STALL_W'(2));
    send_item(ACT_TICK, 24'hA5A5A5);
    send_item(ACT_TICK, 24'hA5A5A5);

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 77; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 77; end
        default: begin send_idle_pct = 34; stall_pct = 34; end
      endcase
      case (p)
        0: set_timeout(STALL_W'(0));
        1: set_timeout(STALL_W'(255));
        2: set_timeout(STALL_W'(1));
        3: set_timeout(STALL_W'(10));
        4: set_timeout(STALL_W'(3));
        5: set_timeout(STALL_W'($urandom_range(0, 255)));
        6: set_timeout(STALL_W'(255));
        default: set_timeout(STALL_W'(2));
      endcase
      random_items(PHASE_ITEMS / 2);
      drain_results();
      random_items(PHASE_ITEMS / 2);
    end
    drain_results();

    if (bad_results == 0) begin
      $display("tb_fan_tach_rpm_with_stall_timeout_top: done, clean");
    end else begin
      $display("tb_fan_tach_rpm_with_stall_timeout_top: done, errors");
    end
    $finish;
  end

endmodule
